>>> rtl/core/mdpq_pkg.sv
// Shared types and constants for the mouse delta packet queue.
package mdpq_pkg;

   localparam int POS_W      = 12;
   localparam int DELTA_W    = 13;
   localparam int MAG_W      = 12;
   localparam int BYTE_W     = 8;
   localparam int PACKET_W   = 24;
   localparam int QUEUED_W   = 10;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int MAX_MAG    = 4095;

   localparam logic [BYTE_W-1:0] HDR_NONE      = 8'h87;
   localparam logic [BYTE_W-1:0] HDR_BTN       = 8'h83;
   localparam logic [BYTE_W-1:0] HDR_BTN_SHIFT = 8'h86;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_COUNT,
      ST_MERGE,
      ST_MERGE_PUT,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [BYTE_W-1:0]       hdr;
   } smp_type;

endpackage

>>> rtl/core/mouse_delta_packet_queue.sv
// Top level of the mouse delta packet queue with its packet store and sequencer.
//
// The request channel carries either a timer sample of the pointer (absolute
// x, y, button and shift) or a read of one queued three-byte packet; req_tuser
// tells which. Every request gives exactly one response on the rsp channel.
// A changed sample is split into packets of at most CHUNK_LIMIT counts per
// axis, which are appended to an internal store of STORE_PACKETS entries plus
// room for one split sample; when the store fills, pending packets are summed
// into one. Requests are handled one at a time by a small sequencer;
// req_tready is high only when it is idle. A merge walks the store through
// its single read port one entry a cycle. The response sits in an output
// register; a new request is accepted while it waits, and a finished request
// holds in its last step until rsp_tready frees the register. Reset empties
// the queue and clears the last position and button state; the store itself
// needs no clearing pass.
module mouse_delta_packet_queue #(
   parameter int STORE_PACKETS = 256,
   parameter int CHUNK_LIMIT   = 127
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x[11:0], pos_y[23:12], button_down[24], shift_down[25], zero fill.
   input  logic [mdpq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[0].
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // header[7:0], delta_x[15:8], delta_y[23:16], queued_bytes[33:24],
   // changed[34], merged[35], zero fill.
   output logic [mdpq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // packet_valid[0].
   output logic                              rsp_tuser
);

   localparam int MAX_SPLIT = (mdpq_pkg::MAX_MAG + CHUNK_LIMIT - 1) / CHUNK_LIMIT;
   localparam int DEPTH     = STORE_PACKETS + MAX_SPLIT + 1;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = $clog2(DEPTH + 1);
   localparam int SUM_W     = mdpq_pkg::BYTE_W + IDX_W + 1;
   localparam int QW        = (IDX_W + 2 > mdpq_pkg::QUEUED_W) ? IDX_W + 2
                                                               : mdpq_pkg::QUEUED_W;
   localparam logic [IDX_W:0]              STORE_LIM = (IDX_W + 1)'(STORE_PACKETS);
   localparam logic [mdpq_pkg::MAG_W-1:0]  CHUNK_MAG = mdpq_pkg::MAG_W'(CHUNK_LIMIT);
   localparam logic signed [SUM_W-1:0]     SAT_HI    = SUM_W'(127);
   localparam logic signed [SUM_W-1:0]     SAT_LO    = -SUM_W'(127);
   localparam logic [mdpq_pkg::BYTE_W-1:0] BYTE_HI   = 8'sd127;
   localparam logic [mdpq_pkg::BYTE_W-1:0] BYTE_LO   = 8'h81;

   mdpq_pkg::state_type state_ff, state_in;
   mdpq_pkg::smp_type   smp_ff, smp_in;

   logic signed [mdpq_pkg::POS_W-1:0] last_x_ff, last_x_in;
   logic signed [mdpq_pkg::POS_W-1:0] last_y_ff, last_y_in;
   logic [mdpq_pkg::BYTE_W-1:0]       last_hdr_ff, last_hdr_in;
   logic [IDX_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]                  wr_idx_ff, wr_idx_in;

   logic [mdpq_pkg::MAG_W-1:0] ax_rem_ff, ax_rem_in;
   logic [mdpq_pkg::MAG_W-1:0] ay_rem_ff, ay_rem_in;
   logic [mdpq_pkg::MAG_W-1:0] cnt_rem_ff, cnt_rem_in;
   logic                       negx_ff, negx_in;
   logic                       negy_ff, negy_in;
   logic [IDX_W-1:0]           num_ff, num_in;
   logic                       single_ff, single_in;
   logic                       pre_ff, pre_in;

   logic [IDX_W-1:0]        mrg_ptr_ff, mrg_ptr_in;
   logic                    mrg_pend_ff, mrg_pend_in;
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;

   logic                        res_pkt_ff, res_pkt_in;
   logic [mdpq_pkg::BYTE_W-1:0] res_hdr_ff, res_hdr_in;
   logic [mdpq_pkg::BYTE_W-1:0] res_dx_ff, res_dx_in;
   logic [mdpq_pkg::BYTE_W-1:0] res_dy_ff, res_dy_in;
   logic                        res_chg_ff, res_chg_in;
   logic                        res_mrg_ff, res_mrg_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_user_ff, rsp_user_in;
   logic [mdpq_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [mdpq_pkg::PACKET_W-1:0] store_mem [DEPTH];
   logic [mdpq_pkg::PACKET_W-1:0] mem_q_ff;
   logic                          mem_we, mem_re;
   logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
   logic [mdpq_pkg::PACKET_W-1:0] mem_wdata;

   logic                               accept;
   logic signed [mdpq_pkg::DELTA_W-1:0] dx, dy;
   logic [mdpq_pkg::DELTA_W-1:0]       dx_abs, dy_abs;
   logic [mdpq_pkg::MAG_W-1:0]         ax, ay;
   logic                               moved;
   logic                               cnt_done;
   logic [IDX_W-1:0]                   n_total;
   logic                               over_multi;
   logic                               over_single;
   logic                               merge_done;
   logic [mdpq_pkg::MAG_W-1:0]         cx, cy;
   logic [mdpq_pkg::BYTE_W-1:0]        bx, by;
   logic [mdpq_pkg::BYTE_W-1:0]        sat_x, sat_y;
   logic [IDX_W-1:0]                   rd_next;
   logic [IDX_W-1:0]                   pend_cnt;
   logic [QW-1:0]                      queued_full;
   logic [mdpq_pkg::BYTE_W-1:0]        req_hdr;

   assign req_tready = (state_ff == mdpq_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign req_hdr = req_tdata[24] ? (req_tdata[25] ? mdpq_pkg::HDR_BTN_SHIFT
                                                   : mdpq_pkg::HDR_BTN)
                                  : mdpq_pkg::HDR_NONE;

   assign dx     = {smp_ff.pos_x[mdpq_pkg::POS_W-1], smp_ff.pos_x}
                 - {last_x_ff[mdpq_pkg::POS_W-1], last_x_ff};
   assign dy     = {last_y_ff[mdpq_pkg::POS_W-1], last_y_ff}
                 - {smp_ff.pos_y[mdpq_pkg::POS_W-1], smp_ff.pos_y};
   assign dx_abs = dx[mdpq_pkg::DELTA_W-1] ? mdpq_pkg::DELTA_W'(0) - dx : dx;
   assign dy_abs = dy[mdpq_pkg::DELTA_W-1] ? mdpq_pkg::DELTA_W'(0) - dy : dy;
   assign ax     = dx_abs[mdpq_pkg::MAG_W-1:0];
   assign ay     = dy_abs[mdpq_pkg::MAG_W-1:0];
   assign moved  = (dx != '0) || (dy != '0) || (smp_ff.hdr != last_hdr_ff);

   assign cnt_done    = (cnt_rem_ff <= CHUNK_MAG);
   assign n_total     = num_ff + IDX_W'(1);
   assign over_multi  = (n_total != IDX_W'(1))
                     && (({1'b0, wr_idx_ff} + {1'b0, n_total}) > STORE_LIM);
   assign over_single = single_ff && (({1'b0, wr_idx_ff} + (IDX_W + 1)'(1)) >= STORE_LIM);
   assign merge_done  = (mrg_ptr_ff >= wr_idx_ff) && !mrg_pend_ff;

   assign cx = (ax_rem_ff > CHUNK_MAG) ? CHUNK_MAG : ax_rem_ff;
   assign cy = (ay_rem_ff > CHUNK_MAG) ? CHUNK_MAG : ay_rem_ff;
   assign bx = negx_ff ? mdpq_pkg::BYTE_W'(0) - cx[mdpq_pkg::BYTE_W-1:0]
                       : cx[mdpq_pkg::BYTE_W-1:0];
   assign by = negy_ff ? mdpq_pkg::BYTE_W'(0) - cy[mdpq_pkg::BYTE_W-1:0]
                       : cy[mdpq_pkg::BYTE_W-1:0];

   assign sat_x = (sum_x_ff > SAT_HI) ? BYTE_HI
                : (sum_x_ff < SAT_LO) ? BYTE_LO : sum_x_ff[mdpq_pkg::BYTE_W-1:0];
   assign sat_y = (sum_y_ff > SAT_HI) ? BYTE_HI
                : (sum_y_ff < SAT_LO) ? BYTE_LO : sum_y_ff[mdpq_pkg::BYTE_W-1:0];

   assign rd_next     = rd_idx_ff + IDX_W'(1);
   assign pend_cnt    = wr_idx_ff - rd_idx_ff;
   assign queued_full = QW'(pend_cnt) + (QW'(pend_cnt) << 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mdpq_pkg::ST_IDLE: begin
            if (accept) begin
               if (mdpq_pkg::cmd_type'(req_tuser) == mdpq_pkg::CMD_READ) begin
                  state_in = (wr_idx_ff > rd_idx_ff) ? mdpq_pkg::ST_READ
                                                     : mdpq_pkg::ST_FINISH;
               end else begin
                  state_in = mdpq_pkg::ST_EVAL;
               end
            end
         end
         mdpq_pkg::ST_READ: begin
            state_in = mdpq_pkg::ST_FINISH;
         end
         mdpq_pkg::ST_EVAL: begin
            state_in = moved ? mdpq_pkg::ST_COUNT : mdpq_pkg::ST_FINISH;
         end
         mdpq_pkg::ST_COUNT: begin
            if (cnt_done) begin
               state_in = over_multi ? mdpq_pkg::ST_MERGE : mdpq_pkg::ST_WRITE;
            end
         end
         mdpq_pkg::ST_MERGE: begin
            if (merge_done) begin
               state_in = mdpq_pkg::ST_MERGE_PUT;
            end
         end
         mdpq_pkg::ST_MERGE_PUT: begin
            state_in = pre_ff ? mdpq_pkg::ST_WRITE : mdpq_pkg::ST_FINISH;
         end
         mdpq_pkg::ST_WRITE: begin
            if (num_ff == IDX_W'(1)) begin
               state_in = over_single ? mdpq_pkg::ST_MERGE : mdpq_pkg::ST_FINISH;
            end
         end
         mdpq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = mdpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      smp_in      = smp_ff;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      last_hdr_in = last_hdr_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      ax_rem_in   = ax_rem_ff;
      ay_rem_in   = ay_rem_ff;
      cnt_rem_in  = cnt_rem_ff;
      negx_in     = negx_ff;
      negy_in     = negy_ff;
      num_in      = num_ff;
      single_in   = single_ff;
      pre_in      = pre_ff;
      mrg_ptr_in  = rd_idx_ff;
      mrg_pend_in = 1'b0;
      sum_x_in    = '0;
      sum_y_in    = '0;
      res_pkt_in  = res_pkt_ff;
      res_hdr_in  = res_hdr_ff;
      res_dx_in   = res_dx_ff;
      res_dy_in   = res_dy_ff;
      res_chg_in  = res_chg_ff;
      res_mrg_in  = res_mrg_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr_idx_ff[ADDR_W-1:0];
      mem_wdata   = {smp_ff.hdr, bx, by};
      mem_re      = 1'b0;
      mem_raddr   = rd_idx_ff[ADDR_W-1:0];

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         mdpq_pkg::ST_IDLE: begin
            if (accept) begin
               smp_in.pos_x = req_tdata[mdpq_pkg::POS_W-1:0];
               smp_in.pos_y = req_tdata[2*mdpq_pkg::POS_W-1:mdpq_pkg::POS_W];
               smp_in.hdr   = req_hdr;
               res_pkt_in   = 1'b0;
               res_hdr_in   = '0;
               res_dx_in    = '0;
               res_dy_in    = '0;
               res_chg_in   = 1'b0;
               res_mrg_in   = 1'b0;
               mem_re       = (mdpq_pkg::cmd_type'(req_tuser) == mdpq_pkg::CMD_READ);
            end
         end
         mdpq_pkg::ST_READ: begin
            res_pkt_in = 1'b1;
            res_hdr_in = mem_q_ff[23:16];
            res_dx_in  = mem_q_ff[15:8];
            res_dy_in  = mem_q_ff[7:0];
            if (rd_next >= wr_idx_ff) begin
               rd_idx_in = '0;
               wr_idx_in = '0;
            end else begin
               rd_idx_in = rd_next;
            end
         end
         mdpq_pkg::ST_EVAL: begin
            if (moved) begin
               last_x_in   = smp_ff.pos_x;
               last_y_in   = smp_ff.pos_y;
               last_hdr_in = smp_ff.hdr;
               ax_rem_in   = ax;
               ay_rem_in   = ay;
               negx_in     = dx[mdpq_pkg::DELTA_W-1];
               negy_in     = dy[mdpq_pkg::DELTA_W-1];
               cnt_rem_in  = (ax > ay) ? ax : ay;
               num_in      = '0;
               res_chg_in  = 1'b1;
            end
         end
         mdpq_pkg::ST_COUNT: begin
            num_in = n_total;
            if (cnt_done) begin
               single_in = (n_total == IDX_W'(1));
               pre_in    = over_multi;
            end else begin
               cnt_rem_in = cnt_rem_ff - CHUNK_MAG;
            end
         end
         mdpq_pkg::ST_MERGE: begin
            mem_raddr = mrg_ptr_ff[ADDR_W-1:0];
            mem_re    = (mrg_ptr_ff < wr_idx_ff);
            mrg_pend_in = mem_re;
            mrg_ptr_in  = mem_re ? mrg_ptr_ff + IDX_W'(1) : mrg_ptr_ff;
            sum_x_in    = sum_x_ff;
            sum_y_in    = sum_y_ff;
            if (mrg_pend_ff) begin
               sum_x_in = sum_x_ff + SUM_W'($signed(mem_q_ff[15:8]));
               sum_y_in = sum_y_ff + SUM_W'($signed(mem_q_ff[7:0]));
            end
         end
         mdpq_pkg::ST_MERGE_PUT: begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = {smp_ff.hdr, sat_x, sat_y};
            rd_idx_in  = '0;
            wr_idx_in  = IDX_W'(1);
            res_mrg_in = 1'b1;
         end
         mdpq_pkg::ST_WRITE: begin
            mem_we    = 1'b1;
            wr_idx_in = wr_idx_ff + IDX_W'(1);
            ax_rem_in = ax_rem_ff - cx;
            ay_rem_in = ay_rem_ff - cy;
            num_in    = num_ff - IDX_W'(1);
         end
         mdpq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_pkt_ff;
               rsp_data_in  = {4'b0000, res_mrg_ff, res_chg_ff,
                               queued_full[mdpq_pkg::QUEUED_W-1:0],
                               res_dy_ff, res_dx_ff, res_hdr_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdpq_pkg::ST_IDLE;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_hdr_ff  <= '0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         mrg_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         last_hdr_ff  <= last_hdr_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         mrg_pend_ff  <= mrg_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      ax_rem_ff   <= ax_rem_in;
      ay_rem_ff   <= ay_rem_in;
      cnt_rem_ff  <= cnt_rem_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      num_ff      <= num_in;
      single_ff   <= single_in;
      pre_ff      <= pre_in;
      mrg_ptr_ff  <= mrg_ptr_in;
      sum_x_ff    <= sum_x_in;
      sum_y_ff    <= sum_y_in;
      res_pkt_ff  <= res_pkt_in;
      res_hdr_ff  <= res_hdr_in;
      res_dx_ff   <= res_dx_in;
      res_dy_ff   <= res_dy_in;
      res_chg_ff  <= res_chg_in;
      res_mrg_ff  <= res_mrg_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= store_mem[mem_raddr];
      end
   end

   // The read pointer never passes the write pointer.
   assert property (@(posedge clock) disable iff (reset) rd_idx_ff <= wr_idx_ff)
      else $error("read index is ahead of write index");

   // An empty queue always sits at entry zero.
   assert property (@(posedge clock) disable iff (reset)
      (rd_idx_ff == wr_idx_ff) |-> (wr_idx_ff == '0))
      else $error("empty queue not rewound to entry zero");

   // The write pointer stays inside the store.
   assert property (@(posedge clock) disable iff (reset) wr_idx_ff <= IDX_W'(DEPTH))
      else $error("write index beyond the store");

   // A merge leaves exactly one packet queued.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mdpq_pkg::ST_MERGE_PUT) |=> (rd_idx_ff == '0 && wr_idx_ff == IDX_W'(1)))
      else $error("merge did not leave a single packet");

   // A request is taken only while no earlier request is in progress.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != mdpq_pkg::ST_IDLE))
      else $error("sequencer stayed idle after accepting a request");

endmodule

>>> tb/sv/mouse_delta_packet_queue_tb.sv
// Self-checking testbench for the mouse delta packet queue, with random stream stalls.
module mouse_delta_packet_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_PACKETS = 256;
   localparam int CHUNK_LIMIT   = 127;
   localparam int RANDOM_REQS   = 550;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 400;
   localparam int GEN           = 0;
   localparam int CHK           = 1;

   typedef struct packed {
      mdpq_pkg::cmd_type                 command;
      logic signed [mdpq_pkg::POS_W-1:0] pos_x;
      logic signed [mdpq_pkg::POS_W-1:0] pos_y;
      logic                              button_down;
      logic                              shift_down;
   } mouse_req_type;

   typedef struct packed {
      logic                          packet_valid;
      logic [mdpq_pkg::BYTE_W-1:0]   header;
      logic [mdpq_pkg::BYTE_W-1:0]   delta_x;
      logic [mdpq_pkg::BYTE_W-1:0]   delta_y;
      logic [mdpq_pkg::QUEUED_W-1:0] queued_bytes;
      logic                          changed;
      logic                          merged;
   } mouse_rsp_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [mdpq_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [mdpq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;

   // Two copies of the queue state: one steers stimulus, one checks responses.
   logic [mdpq_pkg::PACKET_W-1:0] pkt_store [2][0:511];
   int                            rd_idx [2];
   int                            wr_idx [2];
   int                            last_x [2];
   int                            last_y [2];
   logic [mdpq_pkg::BYTE_W-1:0]   last_hdr [2];

   mouse_req_type request_backlog[$];
   mouse_rsp_type due_responses[$];
   mouse_req_type req_on_bus;
   int            total_reqs = 0;
   int            requests_taken = 0;
   int            responses_seen = 0;
   int            mismatches = 0;
   int            cycle_count = 0;

   mouse_delta_packet_queue #(
      .STORE_PACKETS(STORE_PACKETS),
      .CHUNK_LIMIT(CHUNK_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   function automatic void clear_tracker(int s);
      rd_idx[s]   = 0;
      wr_idx[s]   = 0;
      last_x[s]   = 0;
      last_y[s]   = 0;
      last_hdr[s] = '0;
   endfunction

   function automatic int axis_chunk(int d, int i);
      int mag;
      int rest;
      mag  = (d < 0) ? -d : d;
      rest = (mag > i * CHUNK_LIMIT) ? mag - i * CHUNK_LIMIT : 0;
      if (rest > CHUNK_LIMIT) rest = CHUNK_LIMIT;
      return (d < 0) ? -rest : rest;
   endfunction

   // Pending packets collapse into one at entry zero with saturated sums.
   function automatic void merge_pending(int s, logic [mdpq_pkg::BYTE_W-1:0] hdr);
      int sx;
      int sy;
      sx = 0;
      sy = 0;
      for (int i = rd_idx[s]; i < wr_idx[s]; i++) begin
         sx += int'($signed(pkt_store[s][i][15:8]));
         sy += int'($signed(pkt_store[s][i][7:0]));
      end
      if (sx > 127) sx = 127;
      else if (sx < -127) sx = -127;
      if (sy > 127) sy = 127;
      else if (sy < -127) sy = -127;
      pkt_store[s][0] = {hdr, 8'(sx), 8'(sy)};
      rd_idx[s] = 0;
      wr_idx[s] = 1;
   endfunction

   function automatic mouse_rsp_type advance_mouse_queue(int s, mouse_req_type it);
      mouse_rsp_type               r;
      logic [mdpq_pkg::BYTE_W-1:0] hdr;
      int                          dx;
      int                          dy;
      int                          ax;
      int                          ay;
      int                          n;
      r = '0;
      if (it.command == mdpq_pkg::CMD_READ) begin
         if (wr_idx[s] > rd_idx[s]) begin
            {r.header, r.delta_x, r.delta_y} = pkt_store[s][rd_idx[s]];
            r.packet_valid = 1'b1;
            rd_idx[s]++;
            if (rd_idx[s] >= wr_idx[s]) begin
               rd_idx[s] = 0;
               wr_idx[s] = 0;
            end
         end
      end else begin
         hdr = it.button_down ? (it.shift_down ? mdpq_pkg::HDR_BTN_SHIFT : mdpq_pkg::HDR_BTN)
                              : mdpq_pkg::HDR_NONE;
         dx  = int'($signed(it.pos_x)) - last_x[s];
         dy  = last_y[s] - int'($signed(it.pos_y));
         if (dx != 0 || dy != 0 || hdr != last_hdr[s]) begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ay > ax) ax = ay;
            n = (ax == 0) ? 1 : (ax + CHUNK_LIMIT - 1) / CHUNK_LIMIT;
            if (n == 1) begin
               pkt_store[s][wr_idx[s]] = {hdr, 8'(dx), 8'(dy)};
               wr_idx[s]++;
               if (wr_idx[s] >= STORE_PACKETS) begin
                  merge_pending(s, hdr);
                  r.merged = 1'b1;
               end
            end else begin
               if (wr_idx[s] + n > STORE_PACKETS) begin
                  merge_pending(s, hdr);
                  r.merged = 1'b1;
               end
               for (int i = 0; i < n; i++) begin
                  pkt_store[s][wr_idx[s] + i] =
                     {hdr, 8'(axis_chunk(dx, i)), 8'(axis_chunk(dy, i))};
               end
               wr_idx[s] += n;
            end
            last_x[s]   = int'($signed(it.pos_x));
            last_y[s]   = int'($signed(it.pos_y));
            last_hdr[s] = hdr;
            r.changed   = 1'b1;
         end
      end
      r.queued_bytes = mdpq_pkg::QUEUED_W'((wr_idx[s] - rd_idx[s]) * 3);
      return r;
   endfunction

   function automatic int idle_pct(bit sender, int done);
      if (done * 3 < total_reqs) return sender ? 23 : 86;
      if (done * 3 < total_reqs * 2) return sender ? 86 : 23;
      return 0;
   endfunction

   task automatic push_item(mdpq_pkg::cmd_type cmd, int x, int y, int b, int sh);
      mouse_req_type it;
      it.command     = cmd;
      it.pos_x       = mdpq_pkg::POS_W'(x);
      it.pos_y       = mdpq_pkg::POS_W'(y);
      it.button_down = 1'(b);
      it.shift_down  = 1'(sh);
      void'(advance_mouse_queue(GEN, it));
      request_backlog.push_back(it);
   endtask

   task automatic note_mismatch(string what, mouse_rsp_type want, mouse_rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected valid=%0b hdr=%02h dx=%0d dy=%0d queued=%0d chg=%0b mrg=%0b",
                  what, want.packet_valid, want.header, $signed(want.delta_x),
                  $signed(want.delta_y), want.queued_bytes, want.changed, want.merged);
         $display("   got valid=%0b hdr=%02h dx=%0d dy=%0d queued=%0d chg=%0b mrg=%0b",
                  got.packet_valid, got.header, $signed(got.delta_x),
                  $signed(got.delta_y), got.queued_bytes, got.changed, got.merged);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : drive_proc
      mouse_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         clear_tracker(CHK);
      end else begin
         if (req_tvalid && req_tready) begin
            due_responses.push_back(advance_mouse_queue(CHK, req_on_bus));
            requests_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(1'b1, requests_taken)) begin
               nxt        = request_backlog.pop_front();
               req_on_bus = nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, nxt.shift_down, nxt.button_down, nxt.pos_y, nxt.pos_x};
               req_tuser  <= nxt.command;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_proc
      mouse_rsp_type got;
      mouse_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.packet_valid = rsp_tuser;
            got.header       = rsp_tdata[7:0];
            got.delta_x      = rsp_tdata[15:8];
            got.delta_y      = rsp_tdata[23:16];
            got.queued_bytes = rsp_tdata[33:24];
            got.changed      = rsp_tdata[34];
            got.merged       = rsp_tdata[35];
            responses_seen++;
            if (due_responses.size() == 0) begin
               note_mismatch("Response with no request pending", '0, got);
            end else begin
               want = due_responses.pop_front();
               if (got.packet_valid !== want.packet_valid || got.header !== want.header ||
                   got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
                   got.queued_bytes !== want.queued_bytes || got.changed !== want.changed ||
                   got.merged !== want.merged) begin
                  note_mismatch("Response mismatch", want, got);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0, responses_seen));
      end
   end

   initial begin
      int pend;
      int kind;
      int span;
      int nx;
      int ny;
      bit nb;
      bit ns;
      bit filling;
      reset = 1'b1;
      clear_tracker(GEN);

      // A read of the empty store, then the first sample, which always differs from reset.
      push_item(mdpq_pkg::CMD_READ, 0, 0, 0, 0);
      push_item(mdpq_pkg::CMD_SAMPLE, 0, 0, 0, 0);
      push_item(mdpq_pkg::CMD_SAMPLE, 0, 0, 0, 0);
      // Shift without the button still means no button.
      push_item(mdpq_pkg::CMD_SAMPLE, 0, 0, 0, 1);
      push_item(mdpq_pkg::CMD_SAMPLE, 2047, -2048, 1, 0);
      push_item(mdpq_pkg::CMD_SAMPLE, -2048, 2047, 1, 1);
      push_item(mdpq_pkg::CMD_SAMPLE, -2048, 2047, 0, 1);
      // Moves of exactly one and two full chunks.
      push_item(mdpq_pkg::CMD_SAMPLE, -1921, 2047, 0, 0);
      push_item(mdpq_pkg::CMD_SAMPLE, -1667, 2047, 0, 0);
      push_item(mdpq_pkg::CMD_SAMPLE, -1667, 1920, 1, 0);
      push_item(mdpq_pkg::CMD_SAMPLE, -1668, 2047, 1, 0);
      repeat (8) push_item(mdpq_pkg::CMD_READ, 0, 0, 0, 0);

      // Fill bursts push the store into both overflow cases; drain bursts empty it.
      filling = 1'b1;
      for (int k = 0; k < RANDOM_REQS; k++) begin
         pend = wr_idx[GEN] - rd_idx[GEN];
         if (filling) begin
            if ($urandom_range(0, 99) < 3) filling = 1'b0;
         end else if (pend == 0 || $urandom_range(0, 99) < 4) begin
            filling = 1'b1;
         end
         if ($urandom_range(0, 99) < (filling ? 10 : 90)) begin
            push_item(mdpq_pkg::CMD_READ, int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 1)), int'($urandom_range(0, 1)));
         end else begin
            kind = $urandom_range(0, 99);
            if (wr_idx[GEN] > 236 && kind >= 40) kind = 30;
            nx = last_x[GEN];
            ny = last_y[GEN];
            nb = (last_hdr[GEN] == mdpq_pkg::HDR_BTN ||
                  last_hdr[GEN] == mdpq_pkg::HDR_BTN_SHIFT);
            ns = (last_hdr[GEN] == mdpq_pkg::HDR_BTN_SHIFT) ? 1'b1
               : (nb ? 1'b0 : 1'($urandom_range(0, 1)));
            if (kind >= 10 && kind < 22) begin
               nb = 1'($urandom_range(0, 1));
               ns = 1'($urandom_range(0, 1));
            end else if (kind >= 22 && kind < 75) begin
               span = (kind < 55) ? CHUNK_LIMIT : 700;
               nx = nx + int'($urandom_range(0, 2 * span)) - span;
               ny = ny + int'($urandom_range(0, 2 * span)) - span;
               if (nx > 2047) nx = 2047;
               if (nx < -2048) nx = -2048;
               if (ny > 2047) ny = 2047;
               if (ny < -2048) ny = -2048;
               if ($urandom_range(0, 99) < 20) begin
                  nb = 1'($urandom_range(0, 1));
                  ns = 1'($urandom_range(0, 1));
               end
            end else if (kind >= 75) begin
               nx = int'($urandom_range(0, 4095)) - 2048;
               ny = int'($urandom_range(0, 4095)) - 2048;
               nb = 1'($urandom_range(0, 1));
               ns = 1'($urandom_range(0, 1));
            end
            push_item(mdpq_pkg::CMD_SAMPLE, nx, ny, int'(nb), int'(ns));
         end
      end
      total_reqs = request_backlog.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_tvalid || due_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && due_responses.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
